>>> hdl/ltrt_pkg.sv
// Package for the launch-triggered run timer.
// Holds shared constants, mode codes and the controller/datapath command types.
// No dependencies.
package ltrt_pkg;

    localparam int MAX_SAMPLES = 512;
    localparam int CNT_W       = 10;
    localparam int IDX_W       = 9;
    localparam int ROOT_STEPS  = 16;
    localparam int STEP_W      = 4;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DELTA  = 2'd2;

    localparam logic [8:0]  RST_LAUNCH_SPEED = 9'd2;
    localparam logic [8:0]  RST_TARGET_SPEED = 9'd97;
    localparam logic [14:0] RST_ACCEL_DELTA  = 15'd150;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_TAP  = 1'b1;

    typedef enum logic [1:0] {
        MODE_READY   = 2'd0,
        MODE_ARMED   = 2'd1,
        MODE_RUNNING = 2'd2,
        MODE_DONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic              load;
        logic              sq_step;
        logic              rt_step;
        logic              commit;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

>>> hdl/ltrt_ctrl.sv
// Sequencer for the run timer: accept, square the axes, iterate the root,
// then commit the result. Depends on ltrt_pkg.
module ltrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ltrt_pkg::t_stat i_stat,
    output ltrt_pkg::t_cmd  o_cmd
);
    import ltrt_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) n_state = S_SQUARE;
            end
            S_SQUARE: begin
                if (r_step == STEP_W'(2)) begin
                    n_step  = '0;
                    n_state = S_ROOT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_ROOT: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(ROOT_STEPS - 1)) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.step     = r_step;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SQUARE: o_cmd.sq_step = 1'b1;
            S_ROOT:   o_cmd.rt_step = 1'b1;
            S_UPDATE: o_cmd.commit  = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

>>> hdl/ltrt_dp.sv
// Datapath of the run timer: input capture, shared squarer, bit-pair root,
// run state, configuration registers and output register. Depends on ltrt_pkg.
module ltrt_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ltrt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ltrt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_func,
    input  logic [ltrt_pkg::IN_TDATA_W-1:0]   i_data,
    input  ltrt_pkg::t_cmd                    i_cmd,
    output ltrt_pkg::t_stat                   o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ltrt_pkg::OUT_TDATA_W-1:0]  o_out_data,
    output logic                              o_out_last
);
    import ltrt_pkg::*;

    logic [8:0]  r_launch_speed, r_target_speed;
    logic [14:0] r_accel_delta;

    logic        r_func, r_imu;
    logic [31:0] r_now;
    logic [8:0]  r_speed;
    logic [13:0] r_volt;
    logic [15:0] r_curr;
    logic signed [14:0] r_ax, r_ay, r_az;

    logic [29:0] r_acc;
    logic [31:0] r_rem, r_root;

    t_mode            r_mode;
    logic [31:0]      r_launch_time;
    logic [14:0]      r_base_mag;
    logic             r_base_ok;
    logic [CNT_W-1:0] r_count;

    logic                   r_out_valid, r_out_last;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic signed [14:0] sq_in;
    logic signed [29:0] sq_prod;
    logic [31:0] cur_rem, cur_root, rt_bit, rt_trial;
    logic [14:0] mag, mag_diff;
    logic        by_speed, by_imu, running;
    logic [31:0] el, n_elapsed;
    logic        n_valid, n_done;
    t_mode       n_mode;
    logic [31:0] n_launch_time;
    logic [14:0] n_base_mag;
    logic        n_base_ok;
    logic [CNT_W-1:0] n_count;

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_out_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch_speed <= RST_LAUNCH_SPEED;
            r_target_speed <= RST_TARGET_SPEED;
            r_accel_delta  <= RST_ACCEL_DELTA;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LAUNCH_SPEED: r_launch_speed <= i_cfg_data[8:0];
                REG_TARGET_SPEED: r_target_speed <= i_cfg_data[8:0];
                REG_ACCEL_DELTA:  r_accel_delta  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_now   <= i_data[31:0];
            r_speed <= i_data[40:32];
            r_volt  <= i_data[54:41];
            r_curr  <= i_data[70:55];
            r_ax    <= i_data[85:71];
            r_ay    <= i_data[100:86];
            r_az    <= i_data[115:101];
            r_imu   <= i_data[116];
        end
    end

    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    sq_in = r_ax;
            2'd1:    sq_in = r_ay;
            default: sq_in = r_az;
        endcase
    end
    assign sq_prod = 30'(sq_in) * 30'(sq_in);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_step) begin
            r_acc <= ((i_cmd.step == '0) ? 30'd0 : r_acc) + 30'(sq_prod[28:0]);
        end
    end

    always_comb begin
        cur_rem  = (i_cmd.step == '0) ? 32'(r_acc) : r_rem;
        cur_root = (i_cmd.step == '0) ? 32'd0 : r_root;
        rt_bit   = 32'h4000_0000 >> {i_cmd.step, 1'b0};
        rt_trial = cur_root + rt_bit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rt_step) begin
            if (cur_rem >= rt_trial) begin
                r_rem  <= cur_rem - rt_trial;
                r_root <= (cur_root >> 1) + rt_bit;
            end else begin
                r_rem  <= cur_rem;
                r_root <= cur_root >> 1;
            end
        end
    end

    assign mag      = r_root[14:0];
    assign mag_diff = (mag >= r_base_mag) ? mag - r_base_mag : r_base_mag - mag;
    assign by_speed = r_speed > r_launch_speed;
    assign by_imu   = r_base_ok && (mag_diff > r_accel_delta);

    always_comb begin
        n_mode        = r_mode;
        n_launch_time = r_launch_time;
        n_base_mag    = r_base_mag;
        n_base_ok     = r_base_ok;
        n_count       = r_count;
        n_valid       = 1'b0;
        n_done        = 1'b0;
        n_elapsed     = '0;
        running       = 1'b0;
        el            = '0;
        if (r_func == FUNC_TAP) begin
            if (r_mode == MODE_READY) begin
                n_base_ok  = r_imu;
                n_base_mag = r_imu ? mag : 15'd0;
                n_mode     = MODE_ARMED;
            end else if (r_mode == MODE_DONE) begin
                n_count = '0;
                n_mode  = MODE_READY;
            end
        end else begin
            running = (r_mode == MODE_RUNNING);
            if (r_mode == MODE_ARMED && (by_speed || by_imu)) begin
                n_launch_time = r_now;
                n_count       = '0;
                running       = 1'b1;
            end
            if (running) begin
                el = r_now - n_launch_time;
                if (n_count < CNT_W'(MAX_SAMPLES)) begin
                    n_valid   = 1'b1;
                    n_elapsed = el;
                    n_count   = n_count + CNT_W'(1);
                end
                n_mode = MODE_RUNNING;
                if (r_speed >= r_target_speed || n_count >= CNT_W'(MAX_SAMPLES)) begin
                    n_done    = 1'b1;
                    n_elapsed = el;
                    n_mode    = MODE_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_READY;
            r_launch_time <= '0;
            r_base_mag    <= '0;
            r_base_ok     <= 1'b0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_mode        <= n_mode;
                r_launch_time <= n_launch_time;
                r_base_mag    <= n_base_mag;
                r_base_ok     <= n_base_ok;
                r_count       <= n_count;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_last <= n_done;
            r_out_data <= {5'd0,
                           n_valid ? r_curr  : 16'd0,
                           n_valid ? r_volt  : 14'd0,
                           n_valid ? r_speed : 9'd0,
                           n_elapsed,
                           n_valid ? r_count[IDX_W-1:0] : IDX_W'(0),
                           n_valid,
                           n_mode};
        end
    end

endmodule

>>> hdl/launch_triggered_run_timer.sv
// Top level of the launch-triggered run timer.
// Joins ltrt_ctrl and ltrt_dp; depends on ltrt_pkg.
//
//  channel    direction  content
//  s_axis     in         tdata: sample fields, tuser: tick or tap
//  m_axis     out        tdata: mode and recorded sample, tlast: run ends
//  i_cfg_*    in         register writes: launch speed, target speed, delta
//
// A transaction's result enters the output register after the shared squarer
// has taken the three axes, the bit-pair root loop its sixteen steps, and the
// commit. One transaction is worked on at a time, so a new one is accepted only
// after the last is committed; it is taken while the result waits in the
// output register. A stalled m_axis holds the commit. Synchronous reset
// restores the ready mode and register defaults.
module launch_triggered_run_timer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ltrt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ltrt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_ms[31:0], speed_kph[40:32], pack_voltage_dv[54:41],
    // pack_current_da[70:55], accel_x_mg[85:71], accel_y_mg[100:86],
    // accel_z_mg[115:101], imu_ok[116], zero pad
    input  logic [ltrt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // mode[1:0], sample_valid[2], sample_index[11:3], elapsed_ms[43:12],
    // rec_speed_kph[52:44], rec_voltage_dv[66:53], rec_current_da[82:67], zero pad
    output logic [ltrt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // run_done
    output logic                              m_axis_tlast
);
    import ltrt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ltrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ltrt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_func      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
